// ===== rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int KEY_IN_W = 32;

  localparam logic [FUNC_W-1:0] FN_INSERT_SORTED = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FIND          = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT_AT     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE        = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SET           = 3'd4;
  localparam logic [FUNC_W-1:0] FN_GET           = 3'd5;

  typedef struct packed {
    logic take;
    logic bs_init;
    logic bs_probe;
    logic bs_cmp;
    logic pos_to_lo;
    logic cnt_to_lo;
    logic gap_init;
    logic del_init;
    logic scan_init;
    logic step;
    logic shift;
    logic chk;
    logic put_key;
    logic grow;
    logic shrink;
    logic rd_pos;
    logic res_ok;
    logic res_idx;
    logic res_key;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ordering;
    logic              full;
    logic              cnt_zero;
    logic              pos_le_cnt;
    logic              pos_lt_cnt;
    logic              pos_eq_cnt;
    logic              del_ok;
    logic              bs_open;
    logic              move_done;
    logic              hit;
  } status_t;

endpackage

// ===== rtl/sorted_key_table.sv =====
// channel | signals                                  | accepted when
// in      | func, position, run_length, key_in       | in_valid && in_ready
// out     | ok, index_out, key_out, element_count    | out_valid && out_ready
// cfg     | cfg_data (ordering enabled)              | cfg_valid && cfg_ready
//
// One item at a time. Sorted insert: a binary search when ordering is enabled
// (else append), then one key a cycle moved through the memory's read/write
// ports. Delete moves one key a cycle; find scans one key a cycle.
// Synchronous reset empties the table; the key memory itself is not cleared.
// A finished result is held in the output register while the next item starts.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [POS_W-1:0]    position,
  input  logic [POS_W-1:0]    run_length,
  input  logic [KEY_IN_W-1:0] key_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                ok,
  output logic [POS_W-1:0]    index_out,
  output logic [KEY_IN_W-1:0] key_out,
  output logic [POS_W-1:0]    element_count
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = !rst;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  skt_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .st            (st),
    .func          (func),
    .position      (position),
    .run_length    (run_length),
    .key_in        (key_in),
    .ok            (ok),
    .index_out     (index_out),
    .key_out       (key_out),
    .element_count (element_count)
  );

endmodule

// ===== rtl/skt_ctrl.sv =====
module skt_ctrl
  import skt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_BS_PROBE, S_BS_CMP, S_GAP, S_MOVE, S_PUT, S_SET_PUT,
    S_DEL_END, S_SCAN, S_GET_WAIT, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (st.func)
          FN_INSERT_SORTED: begin
            if (!st.full) begin
              if (st.ordering) begin
                cmd.bs_init = 1'b1;
                state_next  = S_BS_PROBE;
              end else begin
                cmd.cnt_to_lo = 1'b1;
                state_next    = S_GAP;
              end
            end
          end
          FN_FIND: begin
            if (st.ordering && !st.cnt_zero) begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          FN_INSERT_AT: begin
            if (!st.full && st.pos_le_cnt) begin
              cmd.pos_to_lo = 1'b1;
              state_next    = S_GAP;
            end
          end
          FN_DELETE: begin
            if (st.del_ok) begin
              cmd.del_init = 1'b1;
              state_next   = S_MOVE;
            end
          end
          FN_SET: begin
            if (st.pos_lt_cnt) begin
              cmd.pos_to_lo = 1'b1;
              state_next    = S_SET_PUT;
            end else if (st.pos_eq_cnt && !st.full) begin
              cmd.pos_to_lo = 1'b1;
              state_next    = S_PUT;
            end
          end
          FN_GET: begin
            if (st.pos_lt_cnt) begin
              cmd.rd_pos = 1'b1;
              state_next = S_GET_WAIT;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_BS_PROBE: begin
        if (st.bs_open) begin
          cmd.bs_probe = 1'b1;
          state_next   = S_BS_CMP;
        end else begin
          state_next = S_GAP;
        end
      end
      S_BS_CMP: begin
        cmd.bs_cmp = 1'b1;
        state_next = S_BS_PROBE;
      end
      S_GAP: begin
        cmd.gap_init = 1'b1;
        state_next   = S_MOVE;
      end
      S_MOVE: begin
        cmd.step  = 1'b1;
        cmd.shift = 1'b1;
        if (st.move_done) begin
          state_next = (st.func == FN_DELETE) ? S_DEL_END : S_PUT;
        end
      end
      S_PUT: begin
        cmd.put_key = 1'b1;
        cmd.grow    = 1'b1;
        cmd.res_ok  = 1'b1;
        cmd.res_idx = 1'b1;
        state_next  = S_FINISH;
      end
      S_SET_PUT: begin
        cmd.put_key = 1'b1;
        cmd.res_ok  = 1'b1;
        cmd.res_idx = 1'b1;
        state_next  = S_FINISH;
      end
      S_DEL_END: begin
        cmd.shrink = 1'b1;
        cmd.res_ok = 1'b1;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        cmd.chk  = 1'b1;
        if (st.hit || st.move_done) begin
          state_next = S_FINISH;
        end
      end
      S_GET_WAIT: begin
        cmd.res_key = 1'b1;
        cmd.res_ok  = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/skt_datapath.sv =====
module skt_datapath
  import skt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic [FUNC_W-1:0]   func,
  input  logic [POS_W-1:0]    position,
  input  logic [POS_W-1:0]    run_length,
  input  logic [KEY_IN_W-1:0] key_in,
  output logic                ok,
  output logic [POS_W-1:0]    index_out,
  output logic [KEY_IN_W-1:0] key_out,
  output logic [POS_W-1:0]    element_count
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int KW     = KEY_WIDTH;

  logic [KW-1:0] key_store [CAPACITY];
  logic [KW-1:0] rdata;

  logic              ordering;
  logic [CNT_W-1:0]  cnt;
  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  len_r;
  logic [KW-1:0]     key_r;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  mid_r;
  logic [CNT_W-1:0]  src;
  logic [CNT_W-1:0]  dst;
  logic [CNT_W-1:0]  moves;
  logic              down;
  logic              pend;
  logic              res_ok;
  logic [POS_W-1:0]  res_idx;
  logic [KW-1:0]     res_key;

  logic [KW+KEY_IN_W-1:0] key_wide;
  logic [KW+KEY_IN_W-1:0] kout_wide;
  logic [CMP_W-1:0]       pos_x;
  logic [CMP_W-1:0]       len_x;
  logic [CMP_W-1:0]       cnt_x;
  logic [CMP_W-1:0]       end_x;
  logic [CNT_W-1:0]       pos_c;
  logic [CNT_W:0]         mid_sum;
  logic [CNT_W-1:0]       mid;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [KW-1:0]          wr_data;
  logic                   hit;

  assign key_wide  = {{KW{1'b0}}, key_in};
  assign kout_wide = {{KEY_IN_W{1'b0}}, res_key};

  assign pos_x   = CMP_W'(pos_r);
  assign len_x   = CMP_W'(len_r);
  assign cnt_x   = CMP_W'(cnt);
  assign end_x   = pos_x + len_x;
  assign pos_c   = CNT_W'(pos_x);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign hit     = pend && (rdata == key_r);

  always_comb begin
    st            = '0;
    st.func       = func_r;
    st.ordering   = ordering;
    st.full       = (cnt == CNT_W'(CAPACITY));
    st.cnt_zero   = (cnt == '0);
    st.pos_le_cnt = (pos_x <= cnt_x);
    st.pos_lt_cnt = (pos_x < cnt_x);
    st.pos_eq_cnt = (pos_x == cnt_x);
    st.del_ok     = (end_x <= cnt_x);
    st.bs_open    = (lo < hi);
    st.move_done  = (moves == '0) && !pend;
    st.hit        = hit;
  end

  // one read and one write port
  always_comb begin
    rd_en   = cmd.bs_probe | cmd.rd_pos | (cmd.step && (moves != '0));
    rd_addr = src[ADDR_W-1:0];
    if (cmd.bs_probe) begin
      rd_addr = mid[ADDR_W-1:0];
    end else if (cmd.rd_pos) begin
      rd_addr = pos_c[ADDR_W-1:0];
    end
    wr_en   = cmd.put_key | (cmd.step && cmd.shift && pend);
    wr_addr = cmd.put_key ? lo[ADDR_W-1:0] : dst[ADDR_W-1:0];
    wr_data = cmd.put_key ? key_r : rdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= key_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering <= 1'b0;
      cnt      <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_write) begin
        ordering <= cfg_data;
      end
      if (cmd.grow) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.shrink) begin
        cnt <= CNT_W'(cnt_x - len_x);
      end
      if (cmd.gap_init || cmd.del_init || cmd.scan_init) begin
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= (moves != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r  <= func;
      pos_r   <= position;
      len_r   <= run_length;
      key_r   <= key_wide[KW-1:0];
      res_ok  <= 1'b0;
      res_idx <= '0;
      res_key <= '0;
    end

    if (cmd.bs_init) begin
      lo <= '0;
      hi <= cnt;
    end else if (cmd.pos_to_lo) begin
      lo <= pos_c;
    end else if (cmd.cnt_to_lo) begin
      lo <= cnt;
    end else if (cmd.bs_cmp) begin
      if (rdata <= key_r) begin
        lo <= mid_r + CNT_W'(1);
      end else begin
        hi <= mid_r;
      end
    end
    if (cmd.bs_probe) begin
      mid_r <= mid;
    end

    if (cmd.gap_init) begin
      src   <= cnt - CNT_W'(1);
      dst   <= cnt;
      moves <= cnt - lo;
      down  <= 1'b1;
    end else if (cmd.del_init) begin
      src   <= CNT_W'(end_x);
      dst   <= pos_c;
      moves <= CNT_W'(cnt_x - end_x);
      down  <= 1'b0;
    end else if (cmd.scan_init) begin
      src   <= '0;
      dst   <= '0;
      moves <= cnt;
      down  <= 1'b0;
    end else if (cmd.step) begin
      if (moves != '0) begin
        src   <= down ? src - CNT_W'(1) : src + CNT_W'(1);
        moves <= moves - CNT_W'(1);
      end
      if (pend) begin
        dst <= down ? dst - CNT_W'(1) : dst + CNT_W'(1);
      end
    end

    if (cmd.chk && hit) begin
      res_ok  <= 1'b1;
      res_idx <= POS_W'(dst);
    end
    if (cmd.res_ok) begin
      res_ok <= 1'b1;
    end
    if (cmd.res_idx) begin
      res_idx <= POS_W'(lo);
    end
    if (cmd.res_key) begin
      res_key <= rdata;
    end

    if (cmd.publish) begin
      ok            <= res_ok;
      index_out     <= res_idx;
      key_out       <= kout_wide[KEY_IN_W-1:0];
      element_count <= POS_W'(cnt);
    end
  end

endmodule

// ===== tb/tb_sorted_key_table.sv =====
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 300;

  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    len;
    logic [KEY_IN_W-1:0] key;
  } table_request_t;

  typedef struct packed {
    logic                ok;
    logic [POS_W-1:0]    idx;
    logic [KEY_IN_W-1:0] key;
    logic [POS_W-1:0]    cnt;
  } table_result_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic                cfg_data   = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func       = '0;
  logic [POS_W-1:0]    position   = '0;
  logic [POS_W-1:0]    run_length = '0;
  logic [KEY_IN_W-1:0] key_in     = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                ok;
  logic [POS_W-1:0]    index_out;
  logic [KEY_IN_W-1:0] key_out;
  logic [POS_W-1:0]    element_count;

  sorted_key_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .position      (position),
    .run_length    (run_length),
    .key_in        (key_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .index_out     (index_out),
    .key_out       (key_out),
    .element_count (element_count)
  );

  logic [KEY_IN_W-1:0] model_keys [CAP];
  int                  model_count    = 0;
  logic                model_ordering = 1'b0;
  table_result_t       pending_results[$];
  int                  mismatches     = 0;
  int                  idle_cycles    = 0;
  int                  rx_hold_req    = 0;
  bit                  tx_steady      = 1'b0;
  bit                  rx_steady      = 1'b0;

  always #10 clk = ~clk;

  function automatic table_request_t req(logic [FUNC_W-1:0] f, int p, int l,
                                         logic [KEY_IN_W-1:0] k);
    table_request_t r;
    r.func = f;
    r.pos  = POS_W'(p);
    r.len  = POS_W'(l);
    r.key  = k;
    return r;
  endfunction

  // Applies one request to the local table copy and returns its result.
  function automatic table_result_t apply_request(table_request_t r);
    table_result_t res;
    int p, lo, hi, mid, pos, len, i;
    res = '0;
    pos = r.pos;
    len = r.len;
    case (r.func)
      FN_INSERT_SORTED, FN_INSERT_AT: begin
        if (r.func == FN_INSERT_AT) begin
          p = pos;
        end else begin
          p = model_count;
          if (model_ordering) begin
            lo = 0;
            hi = model_count;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (model_keys[mid] <= r.key) lo = mid + 1;
              else hi = mid;
            end
            p = lo;
          end
        end
        if (p <= model_count && model_count < CAP) begin
          for (i = model_count; i > p; i--) model_keys[i] = model_keys[i-1];
          model_keys[p] = r.key;
          model_count++;
          res.ok  = 1'b1;
          res.idx = POS_W'(p);
        end
      end
      FN_FIND: begin
        if (model_ordering) begin
          i = 0;
          while (i < model_count && !res.ok) begin
            if (model_keys[i] == r.key) begin
              res.ok  = 1'b1;
              res.idx = POS_W'(i);
            end
            i++;
          end
        end
      end
      FN_DELETE: begin
        if (pos + len <= model_count) begin
          for (i = pos; i + len < model_count; i++) model_keys[i] = model_keys[i+len];
          model_count -= len;
          res.ok = 1'b1;
        end
      end
      FN_SET: begin
        if (pos < model_count || (pos == model_count && model_count < CAP)) begin
          if (pos == model_count) model_count++;
          model_keys[pos] = r.key;
          res.ok  = 1'b1;
          res.idx = POS_W'(pos);
        end
      end
      FN_GET: begin
        if (pos < model_count) begin
          res.ok  = 1'b1;
          res.key = model_keys[pos];
        end
      end
      default: ;
    endcase
    res.cnt = POS_W'(model_count);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic table_request_t random_request();
    table_request_t r;
    int w, p, avail;
    w = $urandom_range(0, 99);
    if (model_count >= CAP - 2 && $urandom_range(0, 2) == 0) w = 60;
    if (w < 26)      r.func = FN_INSERT_SORTED;
    else if (w < 44) r.func = FN_FIND;
    else if (w < 56) r.func = FN_INSERT_AT;
    else if (w < 70) r.func = FN_DELETE;
    else if (w < 82) r.func = FN_SET;
    else if (w < 96) r.func = FN_GET;
    else             r.func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;

    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
    else                           p = $urandom_range(0, model_count);
    r.pos = POS_W'(p);

    avail = (p <= model_count) ? model_count - p : 0;
    w = $urandom_range(0, 99);
    if (r.func != FN_DELETE || w < 10) r.len = POS_W'($urandom_range(0, 127));
    else if (w < 16)                   r.len = POS_W'(avail);
    else                               r.len = POS_W'($urandom_range(0, avail < 4 ? avail : 4));

    w = $urandom_range(0, 99);
    if (w < 40 && model_count > 0) r.key = model_keys[$urandom_range(0, model_count - 1)];
    else if (w < 70)               r.key = KEY_IN_W'($urandom_range(0, 31));
    else if (w < 75)               r.key = $urandom_range(0, 1) ? '1 : '0;
    else                           r.key = $urandom;
    return r;
  endfunction

  task automatic send_request(table_request_t r);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= r.func;
    position   <= r.pos;
    run_length <= r.len;
    key_in     <= r.key;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_results.push_back(apply_request(r));
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ordering(logic value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    model_ordering = value;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ordering off straight after reset: sorted insert appends, find misses
  task automatic test_unordered_mode();
    send_request(req(FN_FIND, 0, 0, '0));
    send_request(req(FN_INSERT_SORTED, 0, 0, '1));
    send_request(req(FN_INSERT_SORTED, 0, 0, '0));
    send_request(req(FN_FIND, 0, 0, '0));
  endtask

  task automatic test_edge_cases();
    send_request(req(FN_FIND, 0, 0, '0));             // lowest match, unsorted keys
    send_request(req(FN_INSERT_AT, 0, 0, '0));
    send_request(req(FN_FIND, 0, 0, '0));
    send_request(req(FN_INSERT_AT, 4, 0, 32'h1));     // beyond count
    send_request(req(FN_INSERT_AT, 3, 0, 32'h5));
    send_request(req(FN_GET, 4, 0, '0));              // at count
    send_request(req(FN_GET, 3, 0, '0));
    send_request(req(FN_SET, 5, 0, 32'h9));           // beyond count
    send_request(req(FN_SET, 4, 0, 32'h7));           // at count, appends
    send_request(req(FN_SET, 0, 0, 32'h8000_0000));
    send_request(req(FN_DELETE, 2, 4, '0));           // run past count
    send_request(req(FN_DELETE, 5, 0, '0));           // empty run
    send_request(req(FN_DELETE, 127, 127, '0));
    send_request(req(FN_DELETE, 1, 2, '0));
    send_request(req(FN_SPARE_6, 0, 0, '0));
    send_request(req(FN_SPARE_7, 127, 127, '1));
    send_request(req(FN_DELETE, 0, 3, '0));
    send_request(req(FN_FIND, 0, 0, '0));             // empty table
    send_request(req(FN_GET, 0, 0, '0));
    send_request(req(FN_INSERT_SORTED, 0, 0, 32'd10));
    send_request(req(FN_INSERT_SORTED, 0, 0, 32'd10));
    send_request(req(FN_INSERT_SORTED, 0, 0, 32'd3));
    send_request(req(FN_INSERT_SORTED, 0, 0, '1));
    send_request(req(FN_INSERT_SORTED, 0, 0, '0));
  endtask

  task automatic test_full_table();
    while (model_count < CAP)
      send_request(req(FN_INSERT_SORTED, 0, 0, KEY_IN_W'($urandom_range(0, 40))));
    send_request(req(FN_INSERT_SORTED, 0, 0, 32'd1));
    send_request(req(FN_INSERT_AT, 0, 0, 32'd2));
    send_request(req(FN_INSERT_AT, CAP, 0, 32'd2));
    send_request(req(FN_SET, CAP, 0, 32'd2));
    send_request(req(FN_FIND, 0, 0, model_keys[40]));
    send_request(req(FN_SET, CAP - 1, 0, $urandom));
    send_request(req(FN_GET, CAP - 1, 0, '0));
    send_request(req(FN_DELETE, 0, 1, '0));
    send_request(req(FN_INSERT_AT, 0, 0, $urandom));
    send_request(req(FN_DELETE, 0, CAP, '0));
  endtask

  task automatic test_random_traffic(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
      end
      send_request(random_request());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver stops for a long stretch while items keep coming back to back
  task automatic test_output_backpressure();
    int i;
    rx_hold_req = HOLD_CYCLES;
    tx_steady   = 1'b1;
    for (i = 0; i < 12; i++) send_request(random_request());
    tx_steady   = 1'b0;
  endtask

  initial begin : receiver
    int  left;
    int  r;
    bit  seg_ready;
    left      = 0;
    seg_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        left        = rx_hold_req;
        seg_ready   = 1'b0;
        rx_hold_req = 0;
      end else if (left <= 0) begin
        if (rx_steady) begin
          seg_ready = 1'b1;
          left      = 1;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            seg_ready = 1'b1;
            left      = $urandom_range(1, 30);
          end else begin
            seg_ready = 1'b0;
            if (r < 85)      left = $urandom_range(1, 3);
            else if (r < 97) left = $urandom_range(4, 20);
            else             left = $urandom_range(30, 80);
          end
        end
      end
      out_ready <= seg_ready;
      left--;
    end
  end

  always @(negedge clk) begin : result_check
    table_result_t want;
    table_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.ok  = ok;
      got.idx = index_out;
      got.key = key_out;
      got.cnt = element_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: ok=%0d idx=%0d key=%h cnt=%0d",
                   got.ok, got.idx, got.key, got.cnt);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.idx !== want.idx ||
            got.key !== want.key || got.cnt !== want.cnt) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch at %0t: expected ok=%0d idx=%0d key=%h cnt=%0d,",
                      " got ok=%0d idx=%0d key=%h cnt=%0d"},
                     $realtime, want.ok, want.idx, want.key, want.cnt,
                     got.ok, got.idx, got.key, got.cnt);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_sorted_key_table: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unordered_mode();
    write_ordering(1'b1);
    test_edge_cases();
    test_full_table();
    test_random_traffic(400);
    write_ordering(1'b0);
    test_random_traffic(250);
    write_ordering(1'b1);
    test_output_backpressure();
    test_random_traffic(450);
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_sorted_key_table: clean");
    end else begin
      $display("tb_sorted_key_table: errors");
    end
    $finish;
  end

endmodule
